/* design/tcp_probe_header_builder_core_defines.svh */
// Assertion macros shared by the checker of the TCP probe header builder.
`ifndef TCP_PROBE_HEADER_BUILDER_CORE_DEFINES_SVH
`define TCP_PROBE_HEADER_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is applied.
`define TPHB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tphb assertion failed");

// Next-cycle implication, masked while reset is applied.
`define TPHB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tphb assertion failed");

// Next-cycle implication that also holds across reset.
`define TPHB_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tphb assertion failed");

`endif

/* design/tphb_pkg.sv */
// Types, constants and checksum helpers for the TCP probe header builder.
package tphb_pkg;

  localparam int unsigned MAX_WORDS  = 10;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IPV4_PORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IPV6_PORT = 2'd1;

  localparam logic ACT_SYN     = 1'b0;
  localparam logic ACT_RST_ACK = 1'b1;

  localparam logic [31:0] IP_WORD0     = 32'h4500_0028;
  localparam logic [15:0] IP_TTL_PROTO = 16'h4006;
  localparam logic [15:0] TCP_LEN      = 16'd20;
  localparam logic [15:0] PROTO_TCP    = 16'd6;
  localparam logic [7:0]  TCP_OFFSET   = 8'h50;
  localparam logic [7:0]  FLAGS_SYN    = 8'h02;
  localparam logic [7:0]  FLAGS_RSTACK = 8'h14;
  localparam logic [15:0] WIN_SYN_V4   = 16'hFFFF;
  localparam logic [15:0] WIN_SYN_V6   = 16'h2000;
  localparam logic [15:0] WIN_RSTACK   = 16'h0000;

  localparam logic [CNT_W-1:0] LEN_V4  = 4'd10;
  localparam logic [CNT_W-1:0] LEN_V6  = 4'd5;
  localparam logic [CNT_W-1:0] LEN_ERR = 4'd1;

  typedef struct packed {
    logic        action;
    logic        v6;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] dport;
    logic [15:0] pid;
    logic [15:0] tick;
    logic [31:0] rseq;
    logic [31:0] rack;
    logic [15:0] sport;
  } req_t;

  typedef struct packed {
    logic            err;
    logic            v6;
    logic [3:0][31:0] tcp;
    logic [15:0]     pid;
    logic [31:0]     s4;
    logic [31:0]     d4;
    logic [20:0]     psum;
    logic [18:0]     tsum;
    logic [19:0]     isum;
  } sums_t;

  typedef struct packed {
    logic            err;
    logic            v6;
    logic [3:0][31:0] tcp;
    logic [15:0]     pid;
    logic [31:0]     s4;
    logic [31:0]     d4;
    logic [16:0]     tfold;
    logic [16:0]     ifold;
  } fold_t;

  typedef struct packed {
    logic                      err;
    logic [CNT_W-1:0]          len;
    logic [MAX_WORDS-1:0][31:0] words;
  } pkt_t;

  function automatic logic [16:0] half_sum(input logic [31:0] w);
    return {1'b0, w[31:16]} + {1'b0, w[15:0]};
  endfunction

  // One end-around carry fold of a sum below 2^21.
  function automatic logic [16:0] fold17(input logic [20:0] x);
    return {1'b0, x[15:0]} + {12'b0, x[20:16]};
  endfunction

endpackage

/* design/tcp_probe_header_builder_core.sv */
// Top level of the TCP probe packet builder.
// Usage:
//   Configure the IPv4 / IPv6 source ports through cfg_we, cfg_index and
//   cfg_wdata while the block is idle; indexes above 1 are ignored.
//   Drive a probe request on the in_ ports with start high; it is taken at a
//   rising edge where busy is low.
//   Each packet word appears on out_packet_word for one cycle with out_valid
//   high; out_last_word marks the final word. IPv4 packets are 10 words
//   (IP header then TCP header), IPv6 packets 5 words (TCP header only).
//   A SYN for a family whose port is zero gives a single word with out_error.
// Flow: the first word leaves after four pipeline stages and then the output
//   shifter load; later words follow one a cycle.
// Throughput: requests enter one a cycle while stages are free; the output
//   shifter moves one word a cycle, so an IPv4 or IPv6 packet holds back the
//   next packet until its last word, and error requests go one per cycle.
// The receiver cannot stall; busy rises when the shifter is full and backs up
//   through the stages. Reset empties all stages and clears both ports.
module tcp_probe_header_builder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_action,
  input  logic                            in_is_ipv6,
  input  logic [63:0]                     in_source_address_high,
  input  logic [63:0]                     in_source_address_low,
  input  logic [63:0]                     in_destination_address_high,
  input  logic [63:0]                     in_destination_address_low,
  input  logic [15:0]                     in_destination_port,
  input  logic [15:0]                     in_probe_id,
  input  logic [15:0]                     in_tick_low,
  input  logic [31:0]                     in_reset_sequence,
  input  logic [31:0]                     in_reset_acknowledge,
  output logic                            out_valid,
  output logic [31:0]                     out_packet_word,
  output logic                            out_last_word,
  output logic                            out_error,
  input  logic                            cfg_we,
  input  logic [tphb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tphb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0]     v4_port_r;
  logic [15:0]     v6_port_r;
  tphb_pkg::req_t  req;
  logic            hdr_ready;
  logic            sums_valid;
  logic            csum_ready;
  tphb_pkg::sums_t sums;
  logic            pkt_valid;
  logic            ser_ready;
  tphb_pkg::pkt_t  pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_port_r <= 16'h0;
      v6_port_r <= 16'h0;
    end else if (cfg_we) begin
      if (cfg_index == tphb_pkg::CFG_IPV4_PORT) v4_port_r <= cfg_wdata;
      if (cfg_index == tphb_pkg::CFG_IPV6_PORT) v6_port_r <= cfg_wdata;
    end
  end

  always_comb begin
    req.action = in_action;
    req.v6     = in_is_ipv6;
    req.src_hi = in_source_address_high;
    req.src_lo = in_source_address_low;
    req.dst_hi = in_destination_address_high;
    req.dst_lo = in_destination_address_low;
    req.dport  = in_destination_port;
    req.pid    = in_probe_id;
    req.tick   = in_tick_low;
    req.rseq   = in_reset_sequence;
    req.rack   = in_reset_acknowledge;
    req.sport  = in_is_ipv6 ? v6_port_r : v4_port_r;
  end

  assign busy = !hdr_ready;

  tphb_hdr u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_req    (req),
    .in_ready  (hdr_ready),
    .out_valid (sums_valid),
    .out_ready (csum_ready),
    .out_sums  (sums)
  );

  tphb_csum u_csum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sums_valid),
    .in_sums   (sums),
    .in_ready  (csum_ready),
    .out_valid (pkt_valid),
    .out_ready (ser_ready),
    .out_pkt   (pkt)
  );

  tphb_ser u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (pkt_valid),
    .in_pkt          (pkt),
    .in_ready        (ser_ready),
    .out_valid       (out_valid),
    .out_packet_word (out_packet_word),
    .out_last_word   (out_last_word),
    .out_error       (out_error)
  );

endmodule

/* design/tphb_hdr.sv */
// Request capture and header field / partial checksum sum stages.
module tphb_hdr (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  tphb_pkg::req_t  in_req,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output tphb_pkg::sums_t out_sums
);

  logic            s1_v_r;
  tphb_pkg::req_t  s1_r;
  logic            s2_v_r;
  tphb_pkg::sums_t s2_r;
  tphb_pkg::sums_t s2_nxt;
  logic            s1_rdy;
  logic            s2_rdy;

  function automatic logic [16:0] half_sum_w(input logic [31:0] w);
    return tphb_pkg::half_sum(w);
  endfunction

  assign s2_rdy    = !s2_v_r || out_ready;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_ready  = s1_rdy;
  assign out_valid = s2_v_r;
  assign out_sums  = s2_r;

  always_comb begin
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [7:0]       flags;
    logic [15:0]      win;
    logic [7:0][31:0] addr;
    logic [20:0]      ps;
    logic [18:0]      ts;
    if (s1_r.action == tphb_pkg::ACT_SYN) begin
      seq   = {s1_r.pid, s1_r.tick};
      ack   = 32'h0;
      flags = tphb_pkg::FLAGS_SYN;
      win   = s1_r.v6 ? tphb_pkg::WIN_SYN_V6 : tphb_pkg::WIN_SYN_V4;
    end else begin
      seq   = s1_r.rseq;
      ack   = s1_r.rack;
      flags = tphb_pkg::FLAGS_RSTACK;
      win   = tphb_pkg::WIN_RSTACK;
    end
    s2_nxt.err    = (s1_r.action == tphb_pkg::ACT_SYN) && (s1_r.sport == 16'h0);
    s2_nxt.v6     = s1_r.v6;
    s2_nxt.tcp[0] = {s1_r.sport, s1_r.dport};
    s2_nxt.tcp[1] = seq;
    s2_nxt.tcp[2] = ack;
    s2_nxt.tcp[3] = {tphb_pkg::TCP_OFFSET, flags, win};
    s2_nxt.pid    = s1_r.pid;
    s2_nxt.s4     = s1_r.src_lo[31:0];
    s2_nxt.d4     = s1_r.dst_lo[31:0];

    // Pseudo header: IPv4 keeps only the two low address words.
    addr = {s1_r.src_hi, s1_r.src_lo, s1_r.dst_hi, s1_r.dst_lo};
    ps   = 21'(tphb_pkg::TCP_LEN) + 21'(tphb_pkg::PROTO_TCP);
    for (int i = 0; i < 8; i++) begin
      if (s1_r.v6 || i == 0 || i == 4) begin
        ps = ps + 21'(half_sum_w(addr[i]));
      end
    end
    s2_nxt.psum = ps;

    ts = 19'h0;
    for (int i = 0; i < 4; i++) begin
      ts = ts + 19'(half_sum_w(s2_nxt.tcp[i]));
    end
    s2_nxt.tsum = ts;

    s2_nxt.isum = 20'(tphb_pkg::half_sum(tphb_pkg::IP_WORD0)) + 20'(s1_r.pid)
                + 20'(tphb_pkg::IP_TTL_PROTO) + 20'(tphb_pkg::half_sum(s2_nxt.s4))
                + 20'(tphb_pkg::half_sum(s2_nxt.d4));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) s1_r <= in_req;
    if (s2_rdy && s1_v_r)   s2_r <= s2_nxt;
  end

endmodule

/* design/tphb_csum.sv */
// Checksum fold, complement and packet word assembly stages.
module tphb_csum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  tphb_pkg::sums_t in_sums,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output tphb_pkg::pkt_t  out_pkt
);

  logic            s3_v_r;
  tphb_pkg::fold_t s3_r;
  tphb_pkg::fold_t s3_nxt;
  logic            s4_v_r;
  tphb_pkg::pkt_t  s4_r;
  tphb_pkg::pkt_t  s4_nxt;
  logic            s3_rdy;
  logic            s4_rdy;

  assign s4_rdy    = !s4_v_r || out_ready;
  assign s3_rdy    = !s3_v_r || s4_rdy;
  assign in_ready  = s3_rdy;
  assign out_valid = s4_v_r;
  assign out_pkt   = s4_r;

  always_comb begin
    s3_nxt.err   = in_sums.err;
    s3_nxt.v6    = in_sums.v6;
    s3_nxt.tcp   = in_sums.tcp;
    s3_nxt.pid   = in_sums.pid;
    s3_nxt.s4    = in_sums.s4;
    s3_nxt.d4    = in_sums.d4;
    s3_nxt.tfold = tphb_pkg::fold17(in_sums.psum + 21'(in_sums.tsum));
    s3_nxt.ifold = tphb_pkg::fold17({1'b0, in_sums.isum});
  end

  always_comb begin
    logic [16:0] tf;
    logic [16:0] icf;
    logic [15:0] tck;
    logic [15:0] ick;
    // Second fold leaves at most 16 bits.
    tf  = tphb_pkg::fold17({4'b0, s3_r.tfold});
    icf = tphb_pkg::fold17({4'b0, s3_r.ifold});
    tck = ~tf[15:0];
    ick = ~icf[15:0];
    s4_nxt.err   = s3_r.err;
    s4_nxt.words = '0;
    if (s3_r.err) begin
      s4_nxt.len = tphb_pkg::LEN_ERR;
    end else if (s3_r.v6) begin
      s4_nxt.len      = tphb_pkg::LEN_V6;
      s4_nxt.words[0] = s3_r.tcp[0];
      s4_nxt.words[1] = s3_r.tcp[1];
      s4_nxt.words[2] = s3_r.tcp[2];
      s4_nxt.words[3] = s3_r.tcp[3];
      s4_nxt.words[4] = {tck, 16'h0};
    end else begin
      s4_nxt.len      = tphb_pkg::LEN_V4;
      s4_nxt.words[0] = tphb_pkg::IP_WORD0;
      s4_nxt.words[1] = {s3_r.pid, 16'h0};
      s4_nxt.words[2] = {tphb_pkg::IP_TTL_PROTO, ick};
      s4_nxt.words[3] = s3_r.s4;
      s4_nxt.words[4] = s3_r.d4;
      s4_nxt.words[5] = s3_r.tcp[0];
      s4_nxt.words[6] = s3_r.tcp[1];
      s4_nxt.words[7] = s3_r.tcp[2];
      s4_nxt.words[8] = s3_r.tcp[3];
      s4_nxt.words[9] = {tck, 16'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_rdy) s3_v_r <= in_valid;
      if (s4_rdy) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && in_valid) s3_r <= s3_nxt;
    if (s4_rdy && s3_v_r)   s4_r <= s4_nxt;
  end

endmodule

/* design/tphb_ser.sv */
// Output shifter: emits one packet word per cycle from a loaded packet.
module tphb_ser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  tphb_pkg::pkt_t in_pkt,
  output logic           in_ready,
  output logic           out_valid,
  output logic [31:0]    out_packet_word,
  output logic           out_last_word,
  output logic           out_error
);

  logic [tphb_pkg::MAX_WORDS-1:0][31:0] words_r;
  logic [tphb_pkg::CNT_W-1:0]           cnt_r;
  logic                                 err_r;

  // Reload on the final word so packets follow without a gap.
  assign in_ready        = (cnt_r <= tphb_pkg::CNT_W'(1));
  assign out_valid       = (cnt_r != '0);
  assign out_packet_word = words_r[0];
  assign out_last_word   = (cnt_r == tphb_pkg::CNT_W'(1));
  assign out_error       = err_r && out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= 1'b0;
    end else if (in_ready && in_valid) begin
      cnt_r <= in_pkt.len;
      err_r <= in_pkt.err;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - tphb_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      words_r <= in_pkt.words;
    end else if (cnt_r != '0) begin
      words_r <= {32'h0, words_r[tphb_pkg::MAX_WORDS-1:1]};
    end
  end

endmodule

/* design/tphb_chk.sv */
// Port-level checker for the TCP probe packet builder, with its bind.
`include "tcp_probe_header_builder_core_defines.svh"

module tphb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_packet_word,
  input logic        out_last_word,
  input logic        out_error
);

  // An error transaction is a lone zero word that closes its packet.
  `TPHB_ASSERT_NOW(a_err_single, out_error, out_valid && out_last_word && out_packet_word == 32'h0)

  // Words of one packet leave on consecutive cycles.
  `TPHB_ASSERT_NEXT(a_pkt_contig, out_valid && !out_last_word, out_valid)

  // A packet still mid-way never carries the error flag on its next word.
  `TPHB_ASSERT_NEXT(a_err_not_mid, out_valid && !out_last_word, !out_error)

  // Reset drains everything and frees the input.
  `TPHB_ASSERT_RST(a_reset_idle, !rst_n, !out_valid && !busy)

endmodule

bind tcp_probe_header_builder_core tphb_chk u_tphb_chk (.*);
